/* sv/fpdt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fpdt_pkg;

   // Magnitude and BCD geometry: 2^63 has 19 decimal digits, one spare
   localparam int MAG_W          = 64;
   localparam int DIGIT_W        = 4;
   localparam int NUM_DIGITS     = 20;
   localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
   localparam int POS_W          = $clog2(NUM_DIGITS);
   localparam int CHAR_W         = 7;

   // Shift-add-3 unit: bits consumed per cycle
   localparam int BITS_PER_CYCLE = 4;
   localparam int CONV_STEPS     = MAG_W / BITS_PER_CYCLE;
   localparam int CNT_W          = $clog2(CONV_STEPS);

   localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_ZERO    = 4'd0;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;

   typedef struct packed {
      logic busy;
      logic done;
   } conv_status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CONV  = 7'b0000010,
      ST_SKIP  = 7'b0000100,
      ST_SIGN  = 7'b0001000,
      ST_INT   = 7'b0010000,
      ST_POINT = 7'b0100000,
      ST_FRAC  = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

/* sv/fpdt_bcd_conv.sv */
`timescale 1ns / 1ps
`default_nettype none

// Iterative binary-to-BCD converter (shift-add-3), a few bits per cycle.
module fpdt_bcd_conv (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [fpdt_pkg::MAG_W-1:0]       mag,
   output fpdt_pkg::conv_status_type             status,
   output logic      [fpdt_pkg::BCD_W-1:0]       bcd
);

   logic [fpdt_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic [fpdt_pkg::BCD_W-1:0] bcd_ff, bcd_in;
   logic [fpdt_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [fpdt_pkg::MAG_W-1:0] mag_work;
   logic [fpdt_pkg::BCD_W-1:0] bcd_work;

   // adjust-and-shift logic, reused on every conversion step
   always_comb begin
      bcd_work = bcd_ff;
      mag_work = mag_ff;
      for (int s = 0; s < fpdt_pkg::BITS_PER_CYCLE; s++) begin
         for (int d = 0; d < fpdt_pkg::NUM_DIGITS; d++) begin
            if (bcd_work[d*fpdt_pkg::DIGIT_W +: fpdt_pkg::DIGIT_W] >= fpdt_pkg::DIGIT_ADJ_MIN)
               bcd_work[d*fpdt_pkg::DIGIT_W +: fpdt_pkg::DIGIT_W] =
                  bcd_work[d*fpdt_pkg::DIGIT_W +: fpdt_pkg::DIGIT_W] + fpdt_pkg::DIGIT_ADJ;
         end
         {bcd_work, mag_work} = {bcd_work[fpdt_pkg::BCD_W-2:0], mag_work, 1'b0};
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = mag;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = mag_work;
         bcd_in = bcd_work;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fpdt_pkg::CNT_W'(fpdt_pkg::CONV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

`default_nettype wire

/* sv/fixed_point_to_decimal_text.sv */
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed 64-bit fixed-point value (scaled by 10^FRACTION_DIGITS)
// into decimal ASCII text, one character per rsp transaction, with rsp_last
// on the final character. Negative values start with '-', the integer part
// has no leading zeros (a lone '0' when it is zero), and a nonzero fraction
// follows a '.' with trailing zeros dropped; 1 to 21 characters per value.
// One value is handled at a time and req_stall is high until the sequencer
// is back in idle. Each value is accepted, converted in the shift-add-3 BCD
// unit (4 bits per cycle over 64 bits) and handed off to the sequencer,
// which skips the leading zero digits (19 minus the position of the top
// nonzero digit, at most 19 - FRACTION_DIGITS) and then sends the
// characters, each waiting while rsp_stall is high. The output register
// lets the next value be accepted while the final character still waits
// on rsp_stall.
module fixed_point_to_decimal_text #(
   parameter int FRACTION_DIGITS = 6
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [63:0]                 req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic             [6:0]                  rsp_character,
   output logic                                    rsp_last
);

   localparam int POS_W = fpdt_pkg::POS_W;
   localparam int DW    = fpdt_pkg::DIGIT_W;
   // BCD position of the units digit of the integer part
   localparam logic [POS_W-1:0] UNITS_POS = POS_W'(FRACTION_DIGITS);
   localparam logic [POS_W-1:0] TOP_POS   = POS_W'(fpdt_pkg::NUM_DIGITS - 1);

   fpdt_pkg::state_type       state_ff, state_in;
   fpdt_pkg::conv_status_type conv_status;

   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       neg_ff, neg_in;
   logic [fpdt_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                       last_ff, last_in;
   logic                       valid_ff, valid_in;

   logic [63:0]                raw;
   logic [fpdt_pkg::MAG_W-1:0] mag;
   logic                       accept;
   logic [fpdt_pkg::BCD_W-1:0] bcd;
   logic [DW-1:0]              digit;
   logic [fpdt_pkg::CHAR_W-1:0] digit_char;
   logic [FRACTION_DIGITS-1:0] frac_nz;
   logic                       any_frac;
   logic                       frac_below;
   logic                       out_free;

   // magnitude as unsigned, so the most negative value yields 2^63
   assign raw    = $unsigned(req_value);
   assign mag    = raw[63] ? (~raw + 64'd1) : raw;
   assign accept = req_valid && !req_stall;

   assign req_stall = (state_ff != fpdt_pkg::ST_IDLE);

   fpdt_bcd_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .mag    (mag),
      .status (conv_status),
      .bcd    (bcd)
   );

   assign digit      = bcd[pos_ff*DW +: DW];
   assign digit_char = fpdt_pkg::CHAR_ZERO + fpdt_pkg::CHAR_W'(digit);

   // nonzero flags of the fraction digits, used for trailing-zero removal
   always_comb begin
      frac_below = 1'b0;
      for (int k = 0; k < FRACTION_DIGITS; k++) begin
         frac_nz[k] = (bcd[k*DW +: DW] != fpdt_pkg::DIGIT_ZERO);
         if ((POS_W'(k) < pos_ff) && frac_nz[k])
            frac_below = 1'b1;
      end
   end
   assign any_frac = |frac_nz;

   // output slot is free when empty or being taken this cycle
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && rsp_stall;
      case (state_ff)
         fpdt_pkg::ST_IDLE: begin
            if (accept) begin
               neg_in   = raw[63];
               state_in = fpdt_pkg::ST_CONV;
            end
         end
         fpdt_pkg::ST_CONV: begin
            if (conv_status.done) begin
               pos_in   = TOP_POS;
               state_in = fpdt_pkg::ST_SKIP;
            end
         end
         fpdt_pkg::ST_SKIP: begin
            // drop leading zeros, keeping at least the units digit
            if ((pos_ff > UNITS_POS) && (digit == fpdt_pkg::DIGIT_ZERO))
               pos_in = pos_ff - 1'b1;
            else if (neg_ff)
               state_in = fpdt_pkg::ST_SIGN;
            else
               state_in = fpdt_pkg::ST_INT;
         end
         fpdt_pkg::ST_SIGN: begin
            if (out_free) begin
               char_in  = fpdt_pkg::CHAR_MINUS;
               last_in  = 1'b0;
               valid_in = 1'b1;
               state_in = fpdt_pkg::ST_INT;
            end
         end
         fpdt_pkg::ST_INT: begin
            if (out_free) begin
               char_in  = digit_char;
               valid_in = 1'b1;
               if (pos_ff == UNITS_POS) begin
                  last_in  = !any_frac;
                  state_in = any_frac ? fpdt_pkg::ST_POINT : fpdt_pkg::ST_IDLE;
               end else begin
                  last_in = 1'b0;
                  pos_in  = pos_ff - 1'b1;
               end
            end
         end
         fpdt_pkg::ST_POINT: begin
            if (out_free) begin
               char_in  = fpdt_pkg::CHAR_POINT;
               last_in  = 1'b0;
               valid_in = 1'b1;
               pos_in   = UNITS_POS - 1'b1;
               state_in = fpdt_pkg::ST_FRAC;
            end
         end
         fpdt_pkg::ST_FRAC: begin
            if (out_free) begin
               char_in  = digit_char;
               valid_in = 1'b1;
               // last once no nonzero digit remains below this one
               last_in  = !frac_below;
               if (!frac_below)
                  state_in = fpdt_pkg::ST_IDLE;
               else
                  pos_in = pos_ff - 1'b1;
            end
         end
         default: begin
            state_in = fpdt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpdt_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      pos_ff  <= pos_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

/* tb/sv/decimal_text_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts the text of each accepted value and
// scores every accepted character against the oldest prediction.
module decimal_text_checker #(
   parameter int FRACTION_DIGITS = 6
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic [63:0]                 req_value,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [fpdt_pkg::CHAR_W-1:0] rsp_character,
   input  wire logic                        rsp_last,
   output int                               failures,
   output int                               pending,
   output int                               values_seen,
   output int                               chars_checked
);

   typedef struct {
      logic [fpdt_pkg::CHAR_W-1:0] character;
      logic                        last;
   } text_char_type;

   text_char_type expected_text[$];

   // Appends the characters that one fixed-point value should produce.
   function automatic void predict_text(input logic [63:0] raw);
      logic [63:0]                 scale;
      logic [63:0]                 mag;
      logic [63:0]                 ipart;
      logic [63:0]                 fpart;
      logic [fpdt_pkg::CHAR_W-1:0] int_digits[$];
      logic [fpdt_pkg::CHAR_W-1:0] frac_digits[FRACTION_DIGITS];
      logic [fpdt_pkg::CHAR_W-1:0] text[$];
      int                          keep;
      int                          i;
      scale = 64'd1;
      for (i = 0; i < FRACTION_DIGITS; i++)
         scale = scale * 64'd10;
      // two's complement magnitude, unsigned so the most negative value fits
      mag   = raw[63] ? (~raw + 64'd1) : raw;
      ipart = mag / scale;
      fpart = mag % scale;
      if (raw[63])
         text.push_back(fpdt_pkg::CHAR_MINUS);
      if (ipart == 64'd0) begin
         text.push_back(fpdt_pkg::CHAR_ZERO);
      end else begin
         while (ipart != 64'd0) begin
            int_digits.push_front(fpdt_pkg::CHAR_ZERO +
                                  fpdt_pkg::CHAR_W'(ipart % 64'd10));
            ipart = ipart / 64'd10;
         end
         foreach (int_digits[k])
            text.push_back(int_digits[k]);
      end
      if (fpart != 64'd0) begin
         text.push_back(fpdt_pkg::CHAR_POINT);
         for (i = FRACTION_DIGITS - 1; i >= 0; i--) begin
            frac_digits[i] = fpdt_pkg::CHAR_ZERO + fpdt_pkg::CHAR_W'(fpart % 64'd10);
            fpart = fpart / 64'd10;
         end
         keep = FRACTION_DIGITS;
         while (keep > 0 && frac_digits[keep-1] == fpdt_pkg::CHAR_ZERO)
            keep--;
         for (i = 0; i < keep; i++)
            text.push_back(frac_digits[i]);
      end
      foreach (text[k])
         expected_text.push_back('{character: text[k], last: (k == text.size() - 1)});
   endfunction

   initial begin
      failures      = 0;
      pending       = 0;
      values_seen   = 0;
      chars_checked = 0;
   end

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_text.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_text(req_value);
            values_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               $error("unexpected character %h (last %b)", rsp_character, rsp_last);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character) begin
                  $error("character: expected %h, actual %h", want.character, rsp_character);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, actual %b", want.last, rsp_last);
                  failures++;
               end
            end
         end
      end
      pending = expected_text.size();
   end

endmodule

/* tb/sv/fixed_point_to_decimal_text_test.sv */
`timescale 1ns / 1ps

// Top of the bench: clock, reset, stimulus on the req channel, back
// pressure on the rsp channel, and the final verdict. All scoring happens
// in the checker instance.
module fixed_point_to_decimal_text_test;

   localparam int FRACTION_DIGITS = 6;
   localparam int RANDOM_ITEMS    = 300;
   localparam int PRESSURE_AT     = 120;   // values sent before the long hold-off
   localparam int HOLD_CYCLES     = 400;   // receiver hold-off length
   localparam int DRAIN_CYCLES    = 64;    // extra wait after the last character
   localparam longint SCALE       = 1000000;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic [63:0]                 req_value = 64'd0;
   logic                        rsp_stall = 1'b0;
   logic                        req_stall;
   logic                        rsp_valid;
   logic [fpdt_pkg::CHAR_W-1:0] rsp_character;
   logic                        rsp_last;

   int failures;
   int pending;
   int values_seen;
   int chars_checked;
   int values_sent = 0;
   bit quiet_phase = 1'b1;   // no gaps and no new stall bursts while set

   // Directed values: extremes, pure fractions, zero fraction, trailing
   // zero trimming, the largest integer parts.
   logic [63:0] directed_values[22] = '{
      64'd0,
      64'd1,
      -64'sd1,
      64'd1000000,
      -64'sd1000000,
      64'd999999,
      64'd500000,
      64'd100000,
      64'd120000,
      64'd10,
      -64'sd500000,
      64'd123000000,
      64'd100000000,
      64'd1234567890123456,
      64'd999999999999999999,
      64'd1000000000000000000,
      64'h7FFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001,
      64'h7FFF_FFFF_FFF0_BDC0,
      -64'sd9223372036854000000,
      64'hFFFF_FFFF_FFFF_FFFF
   };

   always #2 clock = ~clock;

   fixed_point_to_decimal_text #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   decimal_text_checker #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .failures     (failures),
      .pending      (pending),
      .values_seen  (values_seen),
      .chars_checked(chars_checked)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // Random value with a spread of digit counts and fraction shapes.
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      logic [63:0] wide;
      int          k;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = wide;                                   // every bit pattern
         1: v = 64'($urandom_range(0, 2000000));        // near zero, pure fractions
         2: v = (wide >> $urandom_range(21, 63)) * SCALE;  // zero fraction
         3: begin
            // single nonzero fraction digit: trailing zeros to trim
            v = 64'($urandom_range(0, 100000)) * SCALE + 64'($urandom_range(1, 9));
            for (k = $urandom_range(0, FRACTION_DIGITS - 1); k > 0; k--)
               v = v + (v % SCALE) * 9;
         end
         4: v = wide >> $urandom_range(0, 63);          // any magnitude
         default: v = $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3000000)
                                          : 64'h8000_0000_0000_0000 + $urandom_range(0, 3000000);
      endcase
      if ($urandom_range(0, 1) && v != 64'h8000_0000_0000_0000)
         v = ~v + 64'd1;
      return v;
   endfunction

   // Offers one value and holds it until the block takes the transaction.
   task automatic send_value(input logic [63:0] v);
      int gap;
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      values_sent++;
      gap = quiet_phase ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: random stall bursts, quiet stretches, and one long hold-off
   // that backs the block up into its input once enough values have gone in.
   initial begin
      int burst;
      bit held;
      int roll;
      burst = 0;
      held  = 1'b0;
      forever @(posedge clock) begin
         if (!held && values_sent >= PRESSURE_AT) begin
            held  = 1'b1;
            burst = HOLD_CYCLES;
         end
         if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (quiet_phase) begin
            rsp_stall <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               rsp_stall <= 1'b0;
            end else if (roll < 95) begin
               rsp_stall <= 1'b1;
               burst = $urandom_range(0, 3);
            end else begin
               rsp_stall <= 1'b1;
               burst = $urandom_range(10, 40);
            end
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part back to back
      foreach (directed_values[n])
         send_value(directed_values[n]);
      quiet_phase = 1'b0;

      // random part; every fourth block of 40 runs without any idling
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         quiet_phase = ((i / 40) % 4 == 3);
         send_value(random_value());
      end
      quiet_phase = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);

      // drain: all predicted characters must arrive, then nothing extra
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d characters checked): extremes, pure fractions,",
               values_seen, chars_checked);
      $display("trailing-zero trimming, random magnitudes and a %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (failures == 0)
         $display("fixed_point_to_decimal_text_test OK");
      else
         $display("fixed_point_to_decimal_text_test NOT OK");
      $finish;
   end

   // Watchdog: far above the slowest legal run.
   initial begin
      #4000000;
      $display("timeout with %0d characters still expected", pending);
      $display("fixed_point_to_decimal_text_test NOT OK");
      $finish;
   end

endmodule
